>>> design/kxs_pkg.sv
// Shared types and constants for the keyed XOR stream decryptor.
// No dependencies; the top level and kxs_mod refer to it by scoped name.
package kxs_pkg;

  localparam int KEY_LEN_W  = 10;   // key_length register, also residue width
  localparam int IDX_OFF_W  = 17;   // index_offset register
  localparam int POS_W      = 15;   // stream position within a page
  localparam int SQ_W       = 30;   // square of a position
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [POS_W-1:0]     PAGE_LAST        = 15'h7fff;  // position 32767, taken once after the first page ends
  localparam logic [POS_W-1:0]     PAGE_END         = 15'd32766; // last position before wrap
  localparam logic [IDX_OFF_W-1:0] INDEX_OFFSET_RST = 17'd80923;

  localparam logic MODE_KEY_LOAD = 1'b0;
  localparam logic MODE_DECRYPT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIPHER_MODE  = 2'd0,
    CFG_KEY_LENGTH   = 2'd1,
    CFG_INDEX_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       mode;
    logic [8:0] key_index;
    logic [7:0] key_value;
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       chunk_last;
    logic       key_error;
  } out_beat_t;

  // Map cipher byte: shift both ways by the same amount and merge.
  function automatic logic [7:0] map_byte(input logic [7:0] v, input logic [2:0] s);
    return (v << s) | (v >> s);
  endfunction

endpackage

>>> design/keyed_xor_stream_decrypt_top.sv
// Keyed XOR stream decryptor, top level: key store RAM, residue tracking, control.
// Depends on kxs_pkg, kxs_ram and kxs_mod.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | in        | in_valid / in_stall  | in_beat  (kxs_pkg::in_beat_t)
//   out     | out       | out_valid / out_stall| out_beat (kxs_pkg::out_beat_t)
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Key load beat: written to the key RAM in the accept cycle; next beat may follow at once.
// Data beat: accept + key RAM read, then XOR into the output register, as long as the
//   residues are current. The first data beat after reset or after a key_length /
//   index_offset write first rebuilds them with the serial remainder unit.
// Zero key length: result flagged key_error, stream position unchanged.
// Reset (rst_n, synchronous) clears control and position; the key RAM is not cleared.
// A stalled output holds the block in its output state; one result may wait while the
//   next beat is accepted.
module keyed_xor_stream_decrypt_top #(
  parameter int KEY_DEPTH = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beats
  input  logic                               in_valid,
  output logic                               in_stall,
  input  kxs_pkg::in_beat_t                  in_beat,
  // result beats
  output logic                               out_valid,
  input  logic                               out_stall,
  output kxs_pkg::out_beat_t                 out_beat,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kxs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kxs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = $clog2((KEY_DEPTH > 1) ? KEY_DEPTH : 2);
  localparam int LW     = kxs_pkg::KEY_LEN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,   // square the position, launch first remainder
    S_MOD  = 5'b00100,   // remainder unit runs offset, square, step in turn
    S_LOOK = 5'b01000,   // read key RAM with fresh residues
    S_OUT  = 5'b10000    // XOR and load output register
  } state_t;

  typedef enum logic [1:0] {
    OP_OFFSET = 2'd0,
    OP_SQUARE = 2'd1,
    OP_STEP   = 2'd2
  } mod_op_t;

  state_t state_r, state_nxt;
  mod_op_t op_r, op_sel;

  // configuration
  logic                           cipher_mode_r;
  logic [LW-1:0]                  key_length_r;
  logic [kxs_pkg::IDX_OFF_W-1:0]  index_offset_r;
  logic                           dirty_r;      // residues stale
  logic                           cfg_wr;

  // stream position
  logic [kxs_pkg::POS_W-1:0]      page_pos_r, page_pos_nxt;
  logic                           first_page_r, first_page_nxt;
  logic                           at_one_r, at_one_nxt;
  logic [kxs_pkg::POS_W-1:0]      cur_pos;

  // residues mod L for the next data beat:
  //   off = index_offset mod L, sq = pos^2 mod L, d = (2*pos+1) mod L
  logic [LW-1:0]                  off_mod_r;
  logic [LW-1:0]                  sq_mod_r, sq_mod_nxt;
  logic [LW-1:0]                  d_mod_r, d_mod_nxt;
  logic [kxs_pkg::SQ_W-1:0]       sq_full_r, pos_ext;

  logic [LW-1:0]                  len_eff;
  logic                           len_zero;
  logic [LW:0]                    idx_sum, sq_sum, d_sum;
  logic [LW-1:0]                  idx, sq_step, d_step, one_mod, three_mod;

  // beat being worked on
  logic [7:0]                     data_r;
  logic                           last_r, err_r;
  logic [2:0]                     rot_r;

  // handshakes and datapath
  logic                           accept, is_load, is_data;
  logic                           ram_we, ram_re;
  logic [7:0]                     ram_rdata, ks_byte, plain;
  logic                           mod_start, mod_done;
  logic [kxs_pkg::SQ_W-1:0]       mod_dividend;
  logic [LW-1:0]                  mod_rem;
  logic                           out_valid_r, out_free, out_load, advance;
  kxs_pkg::out_beat_t             out_beat_r;

  // ---------------------------------------------------------------- config port
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_mode_r  <= 1'b0;
      key_length_r   <= '0;
      index_offset_r <= kxs_pkg::INDEX_OFFSET_RST;
      dirty_r        <= 1'b1;
    end else begin
      if (state_r == S_MOD && mod_done && op_r == OP_STEP) begin
        dirty_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (kxs_pkg::cfg_reg_t'(cfg_index))
          kxs_pkg::CFG_CIPHER_MODE: begin
            cipher_mode_r <= cfg_data[0];
          end
          kxs_pkg::CFG_KEY_LENGTH: begin
            key_length_r <= cfg_data[LW-1:0];
            dirty_r      <= 1'b1;
          end
          kxs_pkg::CFG_INDEX_OFFSET: begin
            index_offset_r <= cfg_data;
            dirty_r        <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // key length in use, capped at the store depth
  always_comb begin
    if (32'(key_length_r) > KEY_DEPTH) begin
      len_eff = LW'(KEY_DEPTH);
    end else begin
      len_eff = key_length_r;
    end
  end
  assign len_zero = (len_eff == '0);

  // ---------------------------------------------------------------- handshakes
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign is_load  = accept & (in_beat.mode == kxs_pkg::MODE_KEY_LOAD);
  assign is_data  = accept & (in_beat.mode == kxs_pkg::MODE_DECRYPT);

  // ---------------------------------------------------------------- key index
  assign cur_pos = at_one_r ? kxs_pkg::PAGE_LAST : page_pos_r;

  assign idx_sum = {1'b0, sq_mod_r} + {1'b0, off_mod_r};
  assign idx     = (idx_sum >= {1'b0, len_eff}) ? LW'(idx_sum - {1'b0, len_eff})
                                                : idx_sum[LW-1:0];

  // Fast path reads in the accept cycle; after a rebuild the read waits for S_LOOK.
  assign ram_we = is_load && (32'(in_beat.key_index) < KEY_DEPTH);
  assign ram_re = (is_data && !len_zero && !dirty_r) || (state_r == S_LOOK);

  kxs_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_beat.key_index)),
    .wdata (in_beat.key_value),
    .re    (ram_re),
    .raddr (ADDR_W'(idx)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- residue rebuild
  assign pos_ext = kxs_pkg::SQ_W'(cur_pos);

  assign mod_start = (state_r == S_SQ) || (state_r == S_MOD && mod_done && op_r != OP_STEP);

  always_comb begin
    if (state_r == S_SQ) begin
      op_sel = OP_OFFSET;
    end else begin
      op_sel = mod_op_t'(op_r + 2'd1);
    end
    case (op_sel)
      OP_OFFSET: mod_dividend = kxs_pkg::SQ_W'(index_offset_r);
      OP_SQUARE: mod_dividend = sq_full_r;
      OP_STEP:   mod_dividend = kxs_pkg::SQ_W'({cur_pos, 1'b1});
      default:   mod_dividend = '0;
    endcase
  end

  kxs_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (len_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // ---------------------------------------------------------------- position advance
  // Small residues for the two jumps in the position sequence.
  assign one_mod = (len_eff == LW'(1)) ? '0 : LW'(1);
  always_comb begin
    case (len_eff)
      LW'(1):  three_mod = '0;
      LW'(2):  three_mod = LW'(1);
      LW'(3):  three_mod = '0;
      default: three_mod = LW'(3);
    endcase
  end

  // (p+1)^2 = p^2 + (2p+1); the odd term grows by two
  assign sq_sum  = {1'b0, sq_mod_r} + {1'b0, d_mod_r};
  assign sq_step = (sq_sum >= {1'b0, len_eff}) ? LW'(sq_sum - {1'b0, len_eff})
                                               : sq_sum[LW-1:0];
  assign d_sum   = {1'b0, d_mod_r} + (LW+1)'(2);
  always_comb begin
    if (len_eff == LW'(1)) begin
      d_step = '0;
    end else if (d_sum >= {1'b0, len_eff}) begin
      d_step = LW'(d_sum - {1'b0, len_eff});
    end else begin
      d_step = d_sum[LW-1:0];
    end
  end

  always_comb begin
    page_pos_nxt   = page_pos_r + 1'b1;
    first_page_nxt = first_page_r;
    at_one_nxt     = 1'b0;
    sq_mod_nxt     = sq_step;
    d_mod_nxt      = d_step;
    if (at_one_r) begin
      // position 32767 is followed by position 1
      sq_mod_nxt = one_mod;
      d_mod_nxt  = three_mod;
    end else if (page_pos_r == kxs_pkg::PAGE_END) begin
      page_pos_nxt = '0;
      if (first_page_r) begin
        first_page_nxt = 1'b0;
        at_one_nxt     = 1'b1;
      end else begin
        sq_mod_nxt = '0;
        d_mod_nxt  = one_mod;
      end
    end
  end

  // ---------------------------------------------------------------- output stage
  assign ks_byte  = cipher_mode_r ? kxs_pkg::map_byte(ram_rdata, rot_r) : ram_rdata;
  assign plain    = err_r ? 8'h00 : (data_r ^ ks_byte);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;
  assign advance  = out_load && !err_r;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_data) begin
          if (len_zero || !dirty_r) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (mod_done && op_r == OP_STEP) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_OFFSET;
      page_pos_r   <= '0;
      first_page_r <= 1'b1;
      at_one_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SQ) begin
        op_r <= OP_OFFSET;
      end else if (state_r == S_MOD && mod_done && op_r != OP_STEP) begin
        op_r <= op_sel;
      end
      if (advance) begin
        page_pos_r   <= page_pos_nxt;
        first_page_r <= first_page_nxt;
        at_one_r     <= at_one_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (is_data) begin
      data_r <= in_beat.data_byte;
      last_r <= in_beat.chunk_end;
      err_r  <= len_zero;
    end
    if (ram_re) begin
      rot_r <= idx[2:0] + 3'd4;
    end
    if (state_r == S_SQ) begin
      sq_full_r <= pos_ext * pos_ext;
    end
    if (state_r == S_MOD && mod_done) begin
      case (op_r)
        OP_OFFSET: off_mod_r <= mod_rem;
        OP_SQUARE: sq_mod_r  <= mod_rem;
        OP_STEP:   d_mod_r   <= mod_rem;
        default: begin
        end
      endcase
    end else if (advance) begin
      sq_mod_r <= sq_mod_nxt;
      d_mod_r  <= d_mod_nxt;
    end
    if (out_load) begin
      out_beat_r.plain_byte <= plain;
      out_beat_r.chunk_last <= last_r;
      out_beat_r.key_error  <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef ASSERT_OFF
  // remainder unit only reports while the rebuild sequence waits on it
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD)
    else $error("remainder done outside rebuild");

  // a read in the accept cycle needs current residues and a nonzero length
  a_fast_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && ram_re |-> !dirty_r && !len_zero)
    else $error("key read with stale residues");

  // current residues are always reduced below the key length
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    !dirty_r && !len_zero |->
      (off_mod_r < len_eff) && (sq_mod_r < len_eff) && (d_mod_r < len_eff))
    else $error("residue out of range");

  // a non-error result is formed only from a key read issued the cycle before
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !err_r && ($past(state_r) != S_OUT) |-> $past(ram_re))
    else $error("output state entered without key read");
`endif

endmodule

>>> design/kxs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/kxs_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on kxs_pkg for widths.
module kxs_mod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [kxs_pkg::SQ_W-1:0]       dividend,
  input  logic [kxs_pkg::KEY_LEN_W-1:0]  divisor,
  output logic                           done,
  output logic [kxs_pkg::KEY_LEN_W-1:0]  rem
);

  localparam int CNT_W = $clog2(kxs_pkg::SQ_W);

  logic [kxs_pkg::SQ_W-1:0]      shift_r;
  logic [kxs_pkg::KEY_LEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic                          run_r, done_r;
  logic [kxs_pkg::KEY_LEN_W:0]   trial;

  // restoring step; partial remainder stays below divisor
  assign trial = {rem_r, shift_r[kxs_pkg::SQ_W-1]};

  always_comb begin
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = kxs_pkg::KEY_LEN_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[kxs_pkg::KEY_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(kxs_pkg::SQ_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
    end else if (run_r) begin
      shift_r <= shift_r << 1;
      rem_r   <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
